/* rtl/char_lcd_4bit_expander_framer_core_assert.svh */
// assertion macros for the checker file
`ifndef CHAR_LCD_4BIT_EXPANDER_FRAMER_CORE_ASSERT_SVH
`define CHAR_LCD_4BIT_EXPANDER_FRAMER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CLCD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("clcd assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define CLCD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("clcd assertion failed");

`endif

/* rtl/clcd_pkg.sv */
// package: types, codes and constant tables of the lcd expander framer
`timescale 1ns / 1ps
`default_nettype none
package clcd_pkg;

	typedef enum logic [1:0] {
		KIND_POWERUP = 2'd0,
		KIND_CURSOR  = 2'd1,
		KIND_BYTE    = 2'd2,
		KIND_UNUSED  = 2'd3
	} kind_t;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	localparam logic [7:0] CMD_SET_ADDRESS = 8'h80;
	localparam logic [3:0] NIB_LAST_POWERUP = 4'd13;
	localparam logic [3:0] NIB_LAST_BYTE = 4'd1;
	localparam logic [1:0] PHASE_BASE = 2'd0;
	localparam logic [1:0] PHASE_ENABLE = 2'd1;
	localparam logic [1:0] PHASE_END = 2'd2;

	typedef struct packed {
		logic load;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic last_step;
		logic out_free;
	} status_t;

	typedef struct packed {
		logic [3:0] nib;
		logic [5:0] wait_ms;
	} init_nib_t;

	function automatic logic [7:0] line_base(input logic [1:0] row);
		logic [7:0] b;
		case (row)
			2'd0: b = 8'h00;
			2'd1: b = 8'h40;
			2'd2: b = 8'h14;
			2'd3: b = 8'h54;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// power-up nibble stream: 3,3,3,2 then bytes 28 08 01 06 0c
	function automatic init_nib_t init_nibble(input logic [3:0] idx);
		init_nib_t r;
		case (idx)
			4'd0: r = '{nib: 4'h3, wait_ms: 6'd50};
			4'd1: r = '{nib: 4'h3, wait_ms: 6'd5};
			4'd2: r = '{nib: 4'h3, wait_ms: 6'd1};
			4'd3: r = '{nib: 4'h2, wait_ms: 6'd1};
			4'd4: r = '{nib: 4'h2, wait_ms: 6'd1};
			4'd5: r = '{nib: 4'h8, wait_ms: 6'd0};
			4'd6: r = '{nib: 4'h0, wait_ms: 6'd0};
			4'd7: r = '{nib: 4'h8, wait_ms: 6'd0};
			4'd8: r = '{nib: 4'h0, wait_ms: 6'd0};
			4'd9: r = '{nib: 4'h1, wait_ms: 6'd0};
			4'd10: r = '{nib: 4'h0, wait_ms: 6'd2};
			4'd11: r = '{nib: 4'h6, wait_ms: 6'd0};
			4'd12: r = '{nib: 4'h0, wait_ms: 6'd0};
			4'd13: r = '{nib: 4'hC, wait_ms: 6'd0};
			default: r = '{nib: 4'h0, wait_ms: 6'd0};
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/clcd_if.sv */
// channel interfaces: request, result and configuration write
`timescale 1ns / 1ps
`default_nettype none
interface clcd_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] value;
	logic       register_select;
	logic [1:0] row;
	logic [5:0] column;

	modport source (output valid, kind, value, register_select, row, column, input ready);
	modport sink (input valid, kind, value, register_select, row, column, output ready);
endinterface

interface clcd_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] bus_byte;
	logic [5:0] wait_before_ms;
	logic       transfer_end;
	logic       last;

	modport source (output valid, bus_byte, wait_before_ms, transfer_end, last, input ready);
	modport sink (input valid, bus_byte, wait_before_ms, transfer_end, last, output ready);
endinterface

interface clcd_cfg_if;
	logic valid;
	logic ready;
	logic backlight_on;

	modport source (output valid, backlight_on, input ready);
	modport sink (input valid, backlight_on, output ready);
endinterface
`default_nettype wire

/* rtl/clcd_ctrl.sv */
// controller: request acceptance and byte sequencing
`timescale 1ns / 1ps
`default_nettype none
module clcd_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	input  wire logic [1:0]       req_kind,
	output logic                  req_ready,
	input  wire clcd_pkg::status_t status,
	output clcd_pkg::cmd_t        cmd
);
	import clcd_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		req_ready = 1'b0;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				// unused kind is taken and dropped
				if (req_valid && (req_kind != KIND_UNUSED)) begin
					cmd.load = 1'b1;
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					if (status.last_step) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

/* rtl/clcd_datapath.sv */
// datapath: request latch, nibble and phase counters, byte build, output register
`timescale 1ns / 1ps
`default_nettype none
module clcd_datapath (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire clcd_pkg::cmd_t cmd,
	output clcd_pkg::status_t   status,
	input  wire logic [1:0]     req_kind,
	input  wire logic [7:0]     req_value,
	input  wire logic           req_register_select,
	input  wire logic [1:0]     req_row,
	input  wire logic [5:0]     req_column,
	input  wire logic           cfg_we,
	input  wire logic           cfg_backlight_on,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [7:0]          out_bus_byte,
	output logic [5:0]          out_wait_before_ms,
	output logic                out_transfer_end,
	output logic                out_last
);
	import clcd_pkg::*;

	logic       backlight_q;
	logic       pwr_q;
	logic [7:0] byte_q;
	logic       rs_q;
	logic [3:0] nib_q;
	logic [1:0] phase_q;
	logic       out_valid_q;
	logic [7:0] bus_byte_q;
	logic [5:0] wait_q;
	logic       tend_q;
	logic       last_q;

	init_nib_t  init_sel;
	logic [3:0] nib_val;
	logic [5:0] nib_wait;
	logic [3:0] nib_last;
	logic [7:0] addr;
	logic       enable_bit;

	always_comb begin
		init_sel = init_nibble(nib_q);
		if (pwr_q) begin
			nib_val = init_sel.nib;
			nib_wait = init_sel.wait_ms;
			nib_last = NIB_LAST_POWERUP;
		end else begin
			nib_val = nib_q[0] ? byte_q[3:0] : byte_q[7:4];
			nib_wait = 6'd0;
			nib_last = NIB_LAST_BYTE;
		end
		enable_bit = (phase_q == PHASE_ENABLE);
		addr = line_base(req_row) + {2'b00, req_column};
	end

	assign status.last_step = (phase_q == PHASE_END) && (nib_q == nib_last);
	assign status.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			backlight_q <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				backlight_q <= cfg_backlight_on;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request latch and sequence counters
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pwr_q <= (req_kind == KIND_POWERUP);
			rs_q <= (req_kind == KIND_BYTE) ? req_register_select : 1'b0;
			byte_q <= (req_kind == KIND_BYTE) ? req_value : (CMD_SET_ADDRESS | addr);
			nib_q <= '0;
			phase_q <= PHASE_BASE;
		end else if (cmd.emit) begin
			if (phase_q == PHASE_END) begin
				phase_q <= PHASE_BASE;
				nib_q <= nib_q + 4'd1;
			end else begin
				phase_q <= phase_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			bus_byte_q <= {nib_val, backlight_q, enable_bit, 1'b0, rs_q};
			wait_q <= (phase_q == PHASE_BASE) ? nib_wait : 6'd0;
			tend_q <= (phase_q == PHASE_END);
			last_q <= status.last_step;
		end
	end

	assign out_valid = out_valid_q;
	assign out_bus_byte = bus_byte_q;
	assign out_wait_before_ms = wait_q;
	assign out_transfer_end = tend_q;
	assign out_last = last_q;
endmodule
`default_nettype wire

/* rtl/char_lcd_4bit_expander_framer_core.sv */
// one result byte per cycle while the output is taken; 42 bytes for power-up, 6 otherwise
// the first byte goes through the EMIT state and then the output register
// the next request is taken in idle, entered as the last byte enters the output register
// an unused kind is taken and yields nothing
// asynchronous active-low reset: controller idle, output empty, backlight on
// top level: character lcd 4-bit expander framer
`timescale 1ns / 1ps
`default_nettype none
module char_lcd_4bit_expander_framer_core (
	input wire logic clk,
	input wire logic arst_n,
	clcd_req_if.sink   req,
	clcd_rsp_if.source rsp,
	clcd_cfg_if.sink   cfg
);
	import clcd_pkg::*;

	cmd_t    cmd;
	status_t status;

	assign cfg.ready = 1'b1;

	clcd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_kind  (req.kind),
		.req_ready (req.ready),
		.status    (status),
		.cmd       (cmd)
	);

	clcd_datapath u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.status              (status),
		.req_kind            (req.kind),
		.req_value           (req.value),
		.req_register_select (req.register_select),
		.req_row             (req.row),
		.req_column          (req.column),
		.cfg_we              (cfg.valid),
		.cfg_backlight_on    (cfg.backlight_on),
		.out_valid           (rsp.valid),
		.out_ready           (rsp.ready),
		.out_bus_byte        (rsp.bus_byte),
		.out_wait_before_ms  (rsp.wait_before_ms),
		.out_transfer_end    (rsp.transfer_end),
		.out_last            (rsp.last)
	);
endmodule
`default_nettype wire

/* rtl/clcd_checker.sv */
// port checker for the framer top level and its bind
`timescale 1ns / 1ps
`default_nettype none
`include "char_lcd_4bit_expander_framer_core_assert.svh"
module clcd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       valid,
	input wire logic       ready,
	input wire logic [7:0] bus_byte,
	input wire logic [5:0] wait_before_ms,
	input wire logic       transfer_end,
	input wire logic       last
);
	// stalled result holds
	`CLCD_ASSERT_NXT(a_hold, valid && !ready, valid && $stable(bus_byte))
	// a transfer closes with enable low
	`CLCD_ASSERT_IMP(a_end_en_low, valid && transfer_end, !bus_byte[2])
	// a request always ends on a transfer boundary
	`CLCD_ASSERT_IMP(a_last_end, valid && last, transfer_end)
	// waits only ahead of the first byte of a nibble
	`CLCD_ASSERT_IMP(a_wait_first, valid && (wait_before_ms != 6'd0),
		!bus_byte[2] && !transfer_end)
endmodule

bind char_lcd_4bit_expander_framer_core clcd_checker u_clcd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.valid          (rsp.valid),
	.ready          (rsp.ready),
	.bus_byte       (rsp.bus_byte),
	.wait_before_ms (rsp.wait_before_ms),
	.transfer_end   (rsp.transfer_end),
	.last           (rsp.last)
);
`default_nettype wire
